// ===== sv/gdfs_pkg.sv =====
`default_nettype none
package gdfs_pkg;

  // Default sizes handed to the top level parameters
  localparam int DEF_MAX_LISTS     = 8;
  localparam int DEF_LIST_LENGTH   = 8;
  localparam int DEF_STACK_DEPTH   = 8;
  localparam int DEF_VISITED_DEPTH = 8;

  // Pops per traversal before the walk ends
  localparam int MAX_RESULTS = 8;
  localparam int RES_CW      = $clog2(MAX_RESULTS + 1);

  localparam int LABEL_W = 8;

  // Opcodes of an input request
  localparam logic OP_APPEND = 1'b0;
  localparam logic OP_WALK   = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [LABEL_W-1:0] vertex_label;
    logic               ends_list;
  } gdfs_in_t;

  typedef struct packed {
    logic [LABEL_W-1:0] visited_label;
    logic               is_last;
    logic               graph_empty;
  } gdfs_out_t;

  // Controller to datapath commands
  typedef struct packed {
    logic append;      // store one value into the open list
    logic start;       // clear stack, visited store and counters
    logic push_root;   // push head of list 0
    logic pop;         // pop top of stack
    logic load_label;  // capture popped label, restart list search
    logic srch_next;   // advance list search
    logic srch_hit;    // latch the matching list
    logic nb_load;     // capture neighbor, restart visited search
    logic vchk_next;   // advance visited search
    logic push_nb;     // push current neighbor if room
    logic nb_next;     // advance to next neighbor
    logic emit;        // load result register with popped label
    logic emit_empty;  // load empty-graph result
  } gdfs_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic list_empty;
    logic dir_hit;
    logic dir_has_nb;
    logic dir_last;
    logic vis_hit;
    logic vis_last;
    logic nb_more;
    logic res_full;
    logic walk_last;
    logic out_free;
  } gdfs_stat_t;

endpackage
`default_nettype wire

// ===== sv/graph_dfs_adjacency_engine_unit.sv =====
`default_nettype none
// Channel   Direction  Handshake          Payload
// in_       input      in_valid/in_stall  gdfs_in_t  (opcode, vertex_label, ends_list)
// out_      output     out_valid/out_stall gdfs_out_t (visited_label, is_last, graph_empty)
//
// An append request is handled as it is accepted. A walk request seeds the stack
// with the head of list 0, then per pop: pop, load the label, search the lists
// one per cycle (matched by label), then per neighbor load it and compare it with
// the visited entries one per cycle, then load the result register once it is free.
// Requests are taken only while no walk is running; a result left waiting in
// the output register does not block a new request.
// Synchronous active-low reset clears counts and state; memories need no clear.
module graph_dfs_adjacency_engine_unit #(
  parameter int MAX_LISTS     = gdfs_pkg::DEF_MAX_LISTS,
  parameter int LIST_LENGTH   = gdfs_pkg::DEF_LIST_LENGTH,
  parameter int STACK_DEPTH   = gdfs_pkg::DEF_STACK_DEPTH,
  parameter int VISITED_DEPTH = gdfs_pkg::DEF_VISITED_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  gdfs_pkg::gdfs_in_t  in_request,
  output logic                out_valid,
  input  logic                out_stall,
  output gdfs_pkg::gdfs_out_t out_request
);
  import gdfs_pkg::*;

  gdfs_cmd_t  cmd;
  gdfs_stat_t stat;

  // Sequencer
  gdfs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_opcode (in_request.opcode),
    .in_stall  (in_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Lists, stack, visited store and result register
  gdfs_datapath #(
    .MAX_LISTS     (MAX_LISTS),
    .LIST_LENGTH   (LIST_LENGTH),
    .STACK_DEPTH   (STACK_DEPTH),
    .VISITED_DEPTH (VISITED_DEPTH)
  ) u_datapath (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_request  (in_request),
    .cmd         (cmd),
    .stat        (stat),
    .out_stall   (out_stall),
    .out_valid   (out_valid),
    .out_request (out_request)
  );

endmodule
`default_nettype wire

// ===== sv/gdfs_ctrl.sv =====
`default_nettype none
module gdfs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic                in_opcode,
  output logic                in_stall,
  input  gdfs_pkg::gdfs_stat_t stat,
  output gdfs_pkg::gdfs_cmd_t  cmd
);
  import gdfs_pkg::*;

  typedef enum logic [8:0] {
    ST_IDLE  = 9'b000000001,
    ST_ROOT  = 9'b000000010,
    ST_POP   = 9'b000000100,
    ST_LBL   = 9'b000001000,
    ST_SRCH  = 9'b000010000,
    ST_NBRD  = 9'b000100000,
    ST_VCHK  = 9'b001000000,
    ST_FIN   = 9'b010000000,
    ST_EMPTY = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic   accept;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && (state_r == ST_IDLE);

  // Next state and command decode
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (in_opcode == OP_APPEND) begin
            cmd.append = 1'b1;
          end else if (stat.list_empty) begin
            state_nxt = ST_EMPTY;
          end else begin
            cmd.start = 1'b1;
            state_nxt = ST_ROOT;
          end
        end
      end
      ST_ROOT: begin
        cmd.push_root = 1'b1;
        state_nxt     = ST_POP;
      end
      ST_POP: begin
        cmd.pop   = 1'b1;
        state_nxt = ST_LBL;
      end
      ST_LBL: begin
        cmd.load_label = 1'b1;
        state_nxt      = stat.res_full ? ST_FIN : ST_SRCH;
      end
      ST_SRCH: begin
        if (stat.dir_hit) begin
          cmd.srch_hit = 1'b1;
          state_nxt    = stat.dir_has_nb ? ST_NBRD : ST_FIN;
        end else if (stat.dir_last) begin
          state_nxt = ST_FIN;
        end else begin
          cmd.srch_next = 1'b1;
        end
      end
      ST_NBRD: begin
        cmd.nb_load = 1'b1;
        state_nxt   = ST_VCHK;
      end
      ST_VCHK: begin
        if (stat.vis_hit || stat.vis_last) begin
          // neighbor settled: push if new, then move on
          cmd.push_nb = !stat.vis_hit;
          if (stat.nb_more) begin
            cmd.nb_next = 1'b1;
            state_nxt   = ST_NBRD;
          end else begin
            state_nxt = ST_FIN;
          end
        end else begin
          cmd.vchk_next = 1'b1;
        end
      end
      ST_FIN: begin
        if (stat.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = stat.walk_last ? ST_IDLE : ST_POP;
        end
      end
      ST_EMPTY: begin
        if (stat.out_free) begin
          cmd.emit_empty = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== sv/gdfs_datapath.sv =====
`default_nettype none
module gdfs_datapath #(
  parameter int MAX_LISTS     = gdfs_pkg::DEF_MAX_LISTS,
  parameter int LIST_LENGTH   = gdfs_pkg::DEF_LIST_LENGTH,
  parameter int STACK_DEPTH   = gdfs_pkg::DEF_STACK_DEPTH,
  parameter int VISITED_DEPTH = gdfs_pkg::DEF_VISITED_DEPTH
) (
  input  logic                clk,
  input  logic                rst_n,
  input  gdfs_pkg::gdfs_in_t  in_request,
  input  gdfs_pkg::gdfs_cmd_t cmd,
  output gdfs_pkg::gdfs_stat_t stat,
  input  logic                out_stall,
  output logic                out_valid,
  output gdfs_pkg::gdfs_out_t out_request
);
  import gdfs_pkg::*;

  localparam int LIW = (MAX_LISTS > 1) ? $clog2(MAX_LISTS) : 1;
  localparam int LCW = $clog2(MAX_LISTS + 1);
  localparam int LPW = $clog2(LIST_LENGTH);
  localparam int LNW = $clog2(LIST_LENGTH + 1);
  localparam int SIW = $clog2(STACK_DEPTH);
  localparam int SCW = $clog2(STACK_DEPTH + 1);
  localparam int VIW = $clog2(VISITED_DEPTH);
  localparam int VCW = $clog2(VISITED_DEPTH + 1);

  localparam logic [LCW-1:0]    LC_MAX = LCW'(MAX_LISTS);
  localparam logic [LNW-1:0]    LN_MAX = LNW'(LIST_LENGTH);
  localparam logic [SCW-1:0]    SC_MAX = SCW'(STACK_DEPTH);
  localparam logic [VCW-1:0]    VC_MAX = VCW'(VISITED_DEPTH);
  localparam logic [RES_CW-1:0] RC_MAX = RES_CW'(MAX_RESULTS);

  // Storage: list values, per-list head and length, stack, visited store
  logic [LABEL_W-1:0] ent_mem  [1<<(LIW+LPW)];
  logic [LABEL_W-1:0] head_mem [1<<LIW];
  logic [LNW-1:0]     len_mem  [1<<LIW];
  logic [LABEL_W-1:0] stk_mem  [1<<SIW];
  logic [LABEL_W-1:0] vis_mem  [1<<VIW];

  logic [LABEL_W-1:0] ent_rd_r, head_rd_r, stk_rd_r, vis_rd_r;
  logic [LNW-1:0]     len_rd_r;

  logic [LCW-1:0]     list_count_r, list_count_nxt;
  logic [LNW-1:0]     cur_len_r, cur_len_nxt;
  logic [LABEL_W-1:0] cur_head_r, cur_head_nxt;
  logic [SCW-1:0]     sp_r, sp_nxt;
  logic [VCW-1:0]     vc_r, vc_nxt;
  logic [RES_CW-1:0]  res_r, res_nxt;
  logic [LCW-1:0]     j_r, j_nxt;
  logic [LIW-1:0]     jsel_r, jsel_nxt;
  logic [LNW-1:0]     nlen_r, nlen_nxt;
  logic [LNW-1:0]     p_r, p_nxt;
  logic [VCW-1:0]     k_r, k_nxt;
  logic [LABEL_W-1:0] label_r, label_nxt;
  logic [LABEL_W-1:0] nb_r, nb_nxt;
  logic               out_valid_r, out_valid_nxt;
  gdfs_out_t          out_q_r, out_q_nxt;

  logic               room;
  logic               ent_we, dir_we, push_we;
  logic [LNW-1:0]     app_len;
  logic [LABEL_W-1:0] app_head, push_label;

  // Status toward the controller
  always_comb begin
    stat.list_empty = (list_count_r == '0);
    stat.dir_hit    = (head_rd_r == label_r) && (len_rd_r != '0);
    stat.dir_has_nb = (len_rd_r > LNW'(1));
    stat.dir_last   = ((j_r + LCW'(1)) == list_count_r);
    stat.vis_hit    = (vis_rd_r == nb_r);
    stat.vis_last   = ((k_r + VCW'(1)) == vc_r);
    stat.nb_more    = ((p_r + LNW'(1)) < nlen_r);
    stat.res_full   = (res_r == RC_MAX);
    stat.walk_last  = (sp_r == '0) || (res_r == RC_MAX);
    stat.out_free   = !out_valid_r || !out_stall;
  end

  // List loading
  always_comb begin
    room     = (list_count_r < LC_MAX);
    app_len  = (cur_len_r < LN_MAX) ? cur_len_r + LNW'(1) : cur_len_r;
    app_head = (cur_len_r == '0) ? in_request.vertex_label : cur_head_r;
    ent_we   = cmd.append && room && (cur_len_r < LN_MAX);
    dir_we   = cmd.append && room && in_request.ends_list;
  end

  // Push: root head always, new neighbor only while stack and store have room
  always_comb begin
    push_label = cmd.push_root ? head_rd_r : nb_r;
    push_we    = cmd.push_root ||
                 (cmd.push_nb && (sp_r < SC_MAX) && (vc_r < VC_MAX));
  end

  // Walk registers next value
  always_comb begin
    list_count_nxt = list_count_r;
    cur_len_nxt    = cur_len_r;
    cur_head_nxt   = cur_head_r;
    sp_nxt         = sp_r;
    vc_nxt         = vc_r;
    res_nxt        = res_r;
    j_nxt          = j_r;
    jsel_nxt       = jsel_r;
    nlen_nxt       = nlen_r;
    p_nxt          = p_r;
    k_nxt          = k_r;
    label_nxt      = label_r;
    nb_nxt         = nb_r;

    if (cmd.append && room) begin
      cur_len_nxt  = app_len;
      cur_head_nxt = app_head;
      if (in_request.ends_list) begin
        list_count_nxt = list_count_r + LCW'(1);
        cur_len_nxt    = '0;
      end
    end
    if (cmd.start) begin
      sp_nxt  = '0;
      vc_nxt  = '0;
      res_nxt = '0;
      j_nxt   = '0;
    end
    if (push_we) begin
      sp_nxt = sp_r + SCW'(1);
      vc_nxt = vc_r + VCW'(1);
    end
    if (cmd.pop) begin
      sp_nxt  = sp_r - SCW'(1);
      res_nxt = res_r + RES_CW'(1);
    end
    if (cmd.load_label) begin
      label_nxt = stk_rd_r;
      j_nxt     = '0;
    end
    if (cmd.srch_next) begin
      j_nxt = j_r + LCW'(1);
    end
    if (cmd.srch_hit) begin
      jsel_nxt = j_r[LIW-1:0];
      nlen_nxt = len_rd_r;
      p_nxt    = LNW'(1);
    end
    if (cmd.nb_load) begin
      nb_nxt = ent_rd_r;
      k_nxt  = '0;
    end
    if (cmd.vchk_next) begin
      k_nxt = k_r + VCW'(1);
    end
    if (cmd.nb_next) begin
      p_nxt = p_r + LNW'(1);
    end
  end

  // Result register
  always_comb begin
    out_q_nxt     = out_q_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (cmd.emit) begin
      out_q_nxt.visited_label = label_r;
      out_q_nxt.is_last       = stat.walk_last;
      out_q_nxt.graph_empty   = 1'b0;
      out_valid_nxt           = 1'b1;
    end else if (cmd.emit_empty) begin
      out_q_nxt.visited_label = '0;
      out_q_nxt.is_last       = 1'b1;
      out_q_nxt.graph_empty   = 1'b1;
      out_valid_nxt           = 1'b1;
    end
  end

  assign out_valid   = out_valid_r;
  assign out_request = out_q_r;

  // Control and count registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      list_count_r <= '0;
      cur_len_r    <= '0;
      sp_r         <= '0;
      vc_r         <= '0;
      res_r        <= '0;
      j_r          <= '0;
      p_r          <= '0;
      k_r          <= '0;
      nlen_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      list_count_r <= list_count_nxt;
      cur_len_r    <= cur_len_nxt;
      sp_r         <= sp_nxt;
      vc_r         <= vc_nxt;
      res_r        <= res_nxt;
      j_r          <= j_nxt;
      p_r          <= p_nxt;
      k_r          <= k_nxt;
      nlen_r       <= nlen_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    cur_head_r <= cur_head_nxt;
    jsel_r     <= jsel_nxt;
    label_r    <= label_nxt;
    nb_r       <= nb_nxt;
    out_q_r    <= out_q_nxt;
  end

  // Memories: one write and one registered read each, read at next index
  always_ff @(posedge clk) begin
    if (ent_we) begin
      ent_mem[{list_count_r[LIW-1:0], cur_len_r[LPW-1:0]}] <= in_request.vertex_label;
    end
    ent_rd_r <= ent_mem[{jsel_nxt, p_nxt[LPW-1:0]}];
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      head_mem[list_count_r[LIW-1:0]] <= app_head;
      len_mem[list_count_r[LIW-1:0]]  <= app_len;
    end
    head_rd_r <= head_mem[j_nxt[LIW-1:0]];
    len_rd_r  <= len_mem[j_nxt[LIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      stk_mem[sp_r[SIW-1:0]] <= push_label;
    end
    stk_rd_r <= stk_mem[sp_nxt[SIW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (push_we) begin
      vis_mem[vc_r[VIW-1:0]] <= push_label;
    end
    vis_rd_r <= vis_mem[k_nxt[VIW-1:0]];
  end

endmodule
`default_nettype wire

// ===== tb/tb_graph_dfs_adjacency_engine_unit.sv =====
`default_nettype none
module tb_graph_dfs_adjacency_engine_unit;
  import gdfs_pkg::*;

  localparam int N_LISTS   = DEF_MAX_LISTS;
  localparam int LIST_LEN  = DEF_LIST_LENGTH;
  localparam int STACK_LEN = DEF_STACK_DEPTH;
  localparam int SEEN_LEN  = DEF_VISITED_DEPTH;

  // Watchdog limit on the whole simulation, set with wide margin
  localparam int CYCLE_LIMIT  = 1500000;
  localparam int DRAIN_CYCLES = 700;
  localparam int LONG_HOLD    = 400;

  logic      clk        = 1'b0;
  logic      rst_n      = 1'b0;
  logic      in_valid   = 1'b0;
  logic      in_stall;
  gdfs_in_t  in_request = '0;
  logic      out_valid;
  logic      out_stall  = 1'b0;
  gdfs_out_t out_request;

  graph_dfs_adjacency_engine_unit uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_request  (in_request),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_request (out_request)
  );

  always #10 clk = ~clk;

  // Shadow copy of the graph and walk state
  logic [LABEL_W-1:0] adj_vals [N_LISTS*LIST_LEN];
  int                 adj_len [N_LISTS];
  int                 closed_lists = 0;
  logic [LABEL_W-1:0] dfs_stack [STACK_LEN];
  int                 stack_top = 0;
  logic [LABEL_W-1:0] seen_labels [SEEN_LEN];
  int                 seen_count = 0;

  gdfs_out_t walk_results_q[$];
  gdfs_out_t oldest_result;

  int mismatch_count = 0;
  int cycle_count    = 0;
  bit idle_on        = 1'b1;
  int stall_hold     = 0;
  int stall_burst    = 0;

  initial begin
    for (int i = 0; i < N_LISTS; i++) adj_len[i] = 0;
  end

  // Mark and push one label, dropped when stack or visited store is full
  function automatic void push_vertex(input logic [LABEL_W-1:0] lbl);
    if (stack_top >= STACK_LEN || seen_count >= SEEN_LEN) return;
    dfs_stack[stack_top] = lbl;
    stack_top++;
    seen_labels[seen_count] = lbl;
    seen_count++;
  endfunction

  // Update the shadow graph for one accepted request, queue the walk output
  function automatic void predict_request(input gdfs_in_t req);
    gdfs_out_t          pops_q[$];
    gdfs_out_t          res;
    int                 hit;
    int                 j;
    int                 p;
    int                 k;
    bit                 seen;
    logic [LABEL_W-1:0] lbl;
    logic [LABEL_W-1:0] nb;
    if (req.opcode == OP_APPEND) begin
      if (closed_lists >= N_LISTS) return;
      if (adj_len[closed_lists] < LIST_LEN) begin
        adj_vals[closed_lists*LIST_LEN + adj_len[closed_lists]] = req.vertex_label;
        adj_len[closed_lists]++;
      end
      if (req.ends_list) closed_lists++;
      return;
    end
    stack_top  = 0;
    seen_count = 0;
    if (closed_lists == 0) begin
      res.visited_label = '0;
      res.is_last       = 1'b1;
      res.graph_empty   = 1'b1;
      walk_results_q.push_back(res);
      return;
    end
    push_vertex(adj_vals[0]);
    while (stack_top > 0 && pops_q.size() < MAX_RESULTS) begin
      stack_top--;
      lbl = dfs_stack[stack_top];
      res.visited_label = lbl;
      res.is_last       = 1'b0;
      res.graph_empty   = 1'b0;
      pops_q.push_back(res);
      // lowest numbered closed list headed by this label
      hit = -1;
      for (j = 0; j < closed_lists; j++)
        if (hit < 0 && adj_len[j] > 0 && adj_vals[j*LIST_LEN] == lbl) hit = j;
      if (hit >= 0) begin
        for (p = 1; p < adj_len[hit]; p++) begin
          nb = adj_vals[hit*LIST_LEN + p];
          seen = 1'b0;
          for (k = 0; k < seen_count; k++)
            if (seen_labels[k] == nb) seen = 1'b1;
          if (!seen) push_vertex(nb);
        end
      end
    end
    res = pops_q.pop_back();
    res.is_last = 1'b1;
    pops_q.push_back(res);
    foreach (pops_q[i]) walk_results_q.push_back(pops_q[i]);
  endfunction

  task automatic report_mismatch(input string what, input gdfs_out_t want);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%s at cycle %0d:", what, cycle_count);
      $display("  expected label=%0d last=%0b empty=%0b",
               want.visited_label, want.is_last, want.graph_empty);
      $display("  got      label=%0d last=%0b empty=%0b",
               out_request.visited_label, out_request.is_last, out_request.graph_empty);
    end
  endtask

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (walk_results_q.size() == 0) begin
        report_mismatch("unexpected result", '0);
      end else begin
        oldest_result = walk_results_q.pop_front();
        if (out_request.visited_label !== oldest_result.visited_label ||
            out_request.is_last !== oldest_result.is_last ||
            out_request.graph_empty !== oldest_result.graph_empty)
          report_mismatch("result mismatch", oldest_result);
      end
    end
  end

  // Receiver stall: long hold when asked, otherwise random bursts while idling is on
  always @(negedge clk) begin
    if (stall_hold > 0) begin
      out_stall <= 1'b1;
      stall_hold = stall_hold - 1;
    end else if (stall_burst > 0) begin
      out_stall <= 1'b1;
      stall_burst = stall_burst - 1;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      stall_burst = $urandom_range(0, 17);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one request at a falling edge and hold it until accepted
  task automatic send_request(input gdfs_in_t req);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 18);
      repeat (gap) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_request <= req;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_request(req);
    @(negedge clk);
  endtask

  task automatic append_value(input logic [LABEL_W-1:0] lbl, input logic ends);
    gdfs_in_t req;
    req.opcode       = OP_APPEND;
    req.vertex_label = lbl;
    req.ends_list    = ends;
    send_request(req);
  endtask

  // Walk request; unused fields carry random bits
  task automatic walk_graph();
    gdfs_in_t req;
    req.opcode       = OP_WALK;
    req.vertex_label = LABEL_W'($urandom_range(0, 255));
    req.ends_list    = 1'($urandom_range(0, 1));
    send_request(req);
  endtask

  // Change idling mode and stall hold with the input channel parked
  task automatic set_traffic(input bit idle, input int hold);
    in_valid <= 1'b0;
    @(posedge clk);
    idle_on    = idle;
    stall_hold = hold;
    @(negedge clk);
  endtask

  // Labels that tend to link lists to each other
  function automatic logic [LABEL_W-1:0] linked_label();
    case ($urandom_range(0, 12))
      0:       return 8'd10;
      1:       return 8'd20;
      2:       return 8'd30;
      3:       return 8'd0;
      4:       return 8'd42;
      5:       return 8'd43;
      6:       return 8'd44;
      7:       return 8'd45;
      8:       return 8'd50;
      9:       return 8'd51;
      10:      return 8'd52;
      11:      return 8'd53;
      default: return 8'd255;
    endcase
  endfunction

  // Walk on no lists, then with one list still open
  task automatic test_empty_and_open_list();
    walk_graph();
    append_value(8'd10, 1'b0);
    walk_graph();
  endtask

  // Root's neighbor heads no list
  task automatic test_unknown_vertex();
    append_value(8'd20, 1'b1);
    walk_graph();
  endtask

  // Already visited neighbor skipped; second list for the same vertex unused
  task automatic test_revisit_and_duplicate();
    append_value(8'd20, 1'b0);
    append_value(8'd10, 1'b0);
    append_value(8'd30, 1'b1);
    walk_graph();
    append_value(8'd20, 1'b0);
    append_value(8'd255, 1'b1);
    walk_graph();
  endtask

  // Ninth value dropped; walk fills the visited store and hits the pop limit
  task automatic test_full_list_and_visited();
    append_value(8'd30, 1'b0);
    append_value(8'd0, 1'b0);
    for (int v = 42; v <= 47; v++) append_value(v[LABEL_W-1:0], 1'b0);
    append_value(8'd255, 1'b1);
    walk_graph();
  endtask

  // Mixed appends and walks; appends past the last list are not counted
  task automatic run_random(input int count);
    gdfs_in_t req;
    int       done;
    bit       counted;
    done = 0;
    while (done < count) begin
      req.vertex_label = ($urandom_range(0, 1) == 1) ? linked_label()
                                                     : LABEL_W'($urandom_range(0, 255));
      req.ends_list    = ($urandom_range(0, 3) == 0);
      if (closed_lists < N_LISTS)
        req.opcode = ($urandom_range(0, 2) == 0) ? OP_WALK : OP_APPEND;
      else
        req.opcode = ($urandom_range(0, 4) == 0) ? OP_APPEND : OP_WALK;
      counted = (req.opcode == OP_WALK) || (closed_lists < N_LISTS);
      send_request(req);
      if (counted) done++;
    end
  endtask

  // Receiver holds off while walks keep coming, so the input stalls
  task automatic test_backpressure();
    set_traffic(1'b1, LONG_HOLD);
    repeat (4) walk_graph();
  endtask

  initial begin
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_empty_and_open_list();
    test_unknown_vertex();
    test_revisit_and_duplicate();
    test_full_list_and_visited();
    run_random(110);
    test_backpressure();
    run_random(100);
    set_traffic(1'b0, 0);
    run_random(30);

    in_valid <= 1'b0;
    while (walk_results_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && walk_results_q.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
`default_nettype wire

// ===== files.f =====
sv/gdfs_pkg.sv
sv/gdfs_ctrl.sv
sv/gdfs_datapath.sv
sv/graph_dfs_adjacency_engine_unit.sv
tb/tb_graph_dfs_adjacency_engine_unit.sv
